>>> rtl/servo_angle_pulse_sweeper_macros.svh
// assertion helpers for the servo angle pulse sweeper
`ifndef SERVO_ANGLE_PULSE_SWEEPER_MACROS_SVH
`define SERVO_ANGLE_PULSE_SWEEPER_MACROS_SVH

`ifndef SYNTHESIS
`define SAPSW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define SAPSW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define SAPSW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SAPSW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/sapsw_pkg.sv
package sapsw_pkg;

    localparam int PULSE_W    = 15;
    localparam int ANGLE_W    = 8;
    localparam int STEP_W     = 15;
    localparam int DELAY_W    = 16;
    localparam int RSTEP_W    = 16;
    localparam int POS_W      = 17;
    localparam int OFF_W      = 9;
    localparam int SPAN_W     = 16;
    localparam int PROD_W     = 25;
    localparam int MAG_W      = 24;
    localparam int DEN_W      = 8;
    localparam int DIV_CNT_W  = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [PULSE_W-1:0] PULSE_MIN_RST = 15'd1000;
    localparam logic [PULSE_W-1:0] PULSE_MAX_RST = 15'd2000;
    localparam logic [ANGLE_W-1:0] ANGLE_MIN_RST = 8'd0;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX_RST = 8'd180;

    localparam logic [1:0] KIND_SET   = 2'd0;
    localparam logic [1:0] KIND_SWEEP = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd4;

    typedef struct packed {
        logic [1:0]         kind;
        logic [ANGLE_W-1:0] target_angle;
        logic [STEP_W-1:0]  step_us;
        logic [DELAY_W-1:0] step_delay_ms;
    } t_in_item;

    typedef struct packed {
        logic [PULSE_W-1:0] duty_us;
        logic               accepted;
        logic               sweep_done;
    } t_out_item;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [OFF_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP,
        S_DIV,
        S_POST,
        S_EMIT
    } t_state;

    function automatic logic [ANGLE_W-1:0] clamp_angle(
        input logic [ANGLE_W-1:0] a,
        input logic [ANGLE_W-1:0] lo,
        input logic [ANGLE_W-1:0] hi
    );
        // upper bound tested first, matters for a reversed range
        if (a > hi) return hi;
        if (a < lo) return lo;
        return a;
    endfunction

endpackage

>>> rtl/sapsw_div.sv
`include "servo_angle_pulse_sweeper_macros.svh"

module sapsw_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sapsw_pkg::t_div_req i_req,
    output sapsw_pkg::t_div_rsp o_rsp
);
    import sapsw_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic                 r_neg;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [MAG_W-1:0]     r_quo;
    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     r_den;

    logic [PROD_W-1:0]    w_num_abs;
    logic [OFF_W-1:0]     w_den_abs;
    logic [DEN_W:0]       w_shift;
    logic [DEN_W:0]       w_trial;
    logic                 w_fits;

    // magnitudes, sign restored at the end for truncation toward zero
    assign w_num_abs = i_req.dividend[PROD_W-1] ? (~i_req.dividend + 1'b1) : i_req.dividend;
    assign w_den_abs = i_req.divisor[OFF_W-1] ? (~i_req.divisor + 1'b1) : i_req.divisor;

    assign w_shift = {r_rem, r_quo[MAG_W-1]};
    assign w_fits  = (w_shift >= {1'b0, r_den});
    assign w_trial = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == DIV_CNT_W'(MAG_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= w_num_abs[MAG_W-1:0];
            r_den <= w_den_abs[DEN_W-1:0];
            r_rem <= '0;
            r_neg <= i_req.dividend[PROD_W-1] ^ i_req.divisor[OFF_W-1];
        end else if (r_busy) begin
            r_quo <= {r_quo[MAG_W-2:0], w_fits};
            r_rem <= w_fits ? w_trial[DEN_W-1:0] : w_shift[DEN_W-1:0];
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? (~{1'b0, r_quo} + 1'b1) : {1'b0, r_quo};

    `SAPSW_ASSERT_IMPL(a_no_start_busy, i_clk, i_rst_n, i_req.start, !r_busy)
    `SAPSW_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_req.start, r_busy && (r_cnt == '0))
    `SAPSW_ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, r_done, !r_busy)

endmodule

>>> rtl/servo_angle_pulse_sweeper.sv
// an equal angle range skips the divider
// one request at a time: the sequencer stays busy until its result loads into the
// output register, which waits on any output stall; 24-step shared divider
// synchronous active-low reset: registers at defaults, output disabled, no sweep,
// current angle 0; no clearing pass
`include "servo_angle_pulse_sweeper_macros.svh"

module servo_angle_pulse_sweeper (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  sapsw_pkg::t_in_item                  i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output sapsw_pkg::t_out_item                 o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [sapsw_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sapsw_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import sapsw_pkg::*;

    // configuration
    logic [PULSE_W-1:0] r_pulse_min;
    logic [PULSE_W-1:0] r_pulse_max;
    logic [ANGLE_W-1:0] r_angle_min;
    logic [ANGLE_W-1:0] r_angle_max;
    logic               r_enable;

    // sequencer and sweep state
    t_state                    r_state, n_state;
    logic [ANGLE_W-1:0]        r_cur_angle, n_cur_angle;
    logic                      r_active, n_active;
    logic signed [POS_W-1:0]   r_pos, n_pos;
    logic [PULSE_W-1:0]        r_final, n_final;
    logic [ANGLE_W-1:0]        r_goal, n_goal;
    logic signed [RSTEP_W-1:0] r_step, n_step;
    logic [DELAY_W-1:0]        r_delay, n_delay;
    logic [DELAY_W-1:0]        r_tick, n_tick;
    t_in_item                  r_cmd, n_cmd;
    logic [ANGLE_W-1:0]        r_map_angle, n_map_angle;
    logic                      r_phase, n_phase;
    logic [PULSE_W-1:0]        r_start, n_start;
    logic [PULSE_W-1:0]        r_map_res, n_map_res;
    t_out_item                 r_res, n_res;
    logic                      n_div_start;

    logic      r_out_valid;
    t_out_item r_out_data;

    t_div_req  w_div_req;
    t_div_rsp  w_div_rsp;

    logic                      w_in_acc;
    logic                      w_slot_free;
    logic                      w_load;
    logic [ANGLE_W-1:0]        w_map_clamped;
    logic signed [OFF_W-1:0]   w_span_in;
    logic signed [OFF_W-1:0]   w_off;
    logic signed [SPAN_W-1:0]  w_span_out;
    logic signed [PROD_W-1:0]  w_prod;
    logic [PROD_W-1:0]         w_map_sum;
    logic [DELAY_W:0]          w_tick_next;
    logic                      w_due;
    logic signed [POS_W-1:0]   w_final_ext;
    logic signed [POS_W-1:0]   w_step_ext;
    logic                      w_short;
    logic [STEP_W-1:0]         w_step_mag;
    logic signed [RSTEP_W-1:0] w_step_signed;
    logic [ANGLE_W-1:0]        w_clamped;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && (r_state == S_IDLE);
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_load      = (r_state == S_EMIT) && w_slot_free;

    assign w_clamped = clamp_angle(i_in_data.target_angle, r_angle_min, r_angle_max);

    // the mapped angle is clamped again, so a reversed range flips between its ends
    assign w_map_clamped = clamp_angle(r_map_angle, r_angle_min, r_angle_max);

    // linear map: (angle - min) * span_out / span_in + pulse_min
    assign w_span_in  = $signed({1'b0, r_angle_max}) - $signed({1'b0, r_angle_min});
    assign w_off      = $signed({1'b0, w_map_clamped}) - $signed({1'b0, r_angle_min});
    assign w_span_out = $signed({1'b0, r_pulse_max}) - $signed({1'b0, r_pulse_min});
    assign w_prod     = w_off * w_span_out;
    assign w_map_sum  = w_div_rsp.quotient + {{(PROD_W-PULSE_W){1'b0}}, r_pulse_min};

    assign w_div_req.start    = n_div_start;
    assign w_div_req.dividend = w_prod;
    assign w_div_req.divisor  = w_span_in;

    sapsw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // tick path
    assign w_tick_next = {1'b0, r_tick} + 1'b1;
    assign w_due       = !(w_tick_next < {1'b0, r_delay});
    assign w_final_ext = $signed({{(POS_W-PULSE_W){1'b0}}, r_final});
    assign w_step_ext  = POS_W'(r_step);
    assign w_short     = r_step[RSTEP_W-1] ? (r_pos > w_final_ext) : (r_pos < w_final_ext);

    // sweep setup
    assign w_step_mag    = (r_cmd.step_us == '0) ? STEP_W'(1) : r_cmd.step_us;
    assign w_step_signed = (r_map_res > r_start) ? $signed({1'b0, w_step_mag})
                                                 : -$signed({1'b0, w_step_mag});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_min <= PULSE_MIN_RST;
            r_pulse_max <= PULSE_MAX_RST;
            r_angle_min <= ANGLE_MIN_RST;
            r_angle_max <= ANGLE_MAX_RST;
            r_enable    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PULSE_MIN: r_pulse_min <= i_cfg_data[PULSE_W-1:0];
                CFG_PULSE_MAX: r_pulse_max <= i_cfg_data[PULSE_W-1:0];
                CFG_ANGLE_MIN: r_angle_min <= i_cfg_data[ANGLE_W-1:0];
                CFG_ANGLE_MAX: r_angle_max <= i_cfg_data[ANGLE_W-1:0];
                CFG_ENABLE:    r_enable    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cur_angle = r_cur_angle;
        n_active    = r_active;
        n_pos       = r_pos;
        n_final     = r_final;
        n_goal      = r_goal;
        n_step      = r_step;
        n_delay     = r_delay;
        n_tick      = r_tick;
        n_cmd       = r_cmd;
        n_map_angle = r_map_angle;
        n_phase     = r_phase;
        n_start     = r_start;
        n_map_res   = r_map_res;
        n_res       = r_res;
        n_div_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_cmd = i_in_data;
                    case (i_in_data.kind)
                        KIND_SET: begin
                            n_active = 1'b0;
                            if (!r_enable) begin
                                n_res   = '{duty_us: '0, accepted: 1'b0, sweep_done: 1'b0};
                                n_state = S_EMIT;
                            end else begin
                                n_cur_angle = w_clamped;
                                n_map_angle = w_clamped;
                                n_phase     = 1'b0;
                                n_state     = S_MAP;
                            end
                        end
                        KIND_SWEEP: begin
                            if (!r_enable) begin
                                n_res   = '{duty_us: '0, accepted: 1'b0, sweep_done: 1'b0};
                                n_state = S_EMIT;
                            end else begin
                                n_goal      = w_clamped;
                                n_map_angle = r_cur_angle;
                                n_phase     = 1'b0;
                                n_state     = S_MAP;
                            end
                        end
                        KIND_TICK: begin
                            if (r_active && r_enable) begin
                                if (!w_due) begin
                                    n_tick = w_tick_next[DELAY_W-1:0];
                                end else begin
                                    n_tick  = '0;
                                    n_state = S_EMIT;
                                    if (w_short) begin
                                        n_pos = r_pos + w_step_ext;
                                        n_res = '{duty_us: r_pos[PULSE_W-1:0], accepted: 1'b1,
                                                  sweep_done: 1'b0};
                                    end else begin
                                        n_active    = 1'b0;
                                        n_cur_angle = r_goal;
                                        n_res = '{duty_us: r_final, accepted: 1'b1,
                                                  sweep_done: 1'b1};
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_MAP: begin
                // equal angle range maps to pulse_min with no division
                if (w_span_in == '0) begin
                    n_map_res = r_pulse_min;
                    n_state   = S_POST;
                end else begin
                    n_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_map_res = w_map_sum[PULSE_W-1:0];
                    n_state   = S_POST;
                end
            end
            S_POST: begin
                if (r_cmd.kind == KIND_SET) begin
                    n_res   = '{duty_us: r_map_res, accepted: 1'b1, sweep_done: 1'b1};
                    n_state = S_EMIT;
                end else if (!r_phase) begin
                    // start width done, now the goal width
                    n_start     = r_map_res;
                    n_map_angle = r_goal;
                    n_phase     = 1'b1;
                    n_state     = S_MAP;
                end else begin
                    n_state = S_EMIT;
                    if ((r_goal == r_cur_angle) || (r_start == r_map_res)) begin
                        n_active    = 1'b0;
                        n_cur_angle = r_goal;
                        n_res = '{duty_us: r_map_res, accepted: 1'b1, sweep_done: 1'b1};
                    end else begin
                        n_step   = w_step_signed;
                        n_pos    = $signed({{(POS_W-PULSE_W){1'b0}}, r_start})
                                   + POS_W'(w_step_signed);
                        n_final  = r_map_res;
                        n_delay  = r_cmd.step_delay_ms;
                        n_tick   = '0;
                        n_active = 1'b1;
                        n_res = '{duty_us: r_start, accepted: 1'b1, sweep_done: 1'b0};
                    end
                end
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur_angle <= '0;
            r_active    <= 1'b0;
            r_tick      <= '0;
        end else begin
            r_state     <= n_state;
            r_cur_angle <= n_cur_angle;
            r_active    <= n_active;
            r_tick      <= n_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_final     <= n_final;
        r_goal      <= n_goal;
        r_step      <= n_step;
        r_delay     <= n_delay;
        r_cmd       <= n_cmd;
        r_map_angle <= n_map_angle;
        r_phase     <= n_phase;
        r_start     <= n_start;
        r_map_res   <= n_map_res;
        r_res       <= n_res;
    end

    // output register, frees the sequencer while a result waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `SAPSW_ASSERT_NEXT(a_div_to_post, i_clk, i_rst_n, (r_state == S_DIV) && w_div_rsp.done, r_state == S_POST)
    `SAPSW_ASSERT_IMPL(a_step_nonzero, i_clk, i_rst_n, r_active, r_step != '0)
    `SAPSW_ASSERT_IMPL(a_done_accepted, i_clk, i_rst_n, o_out_valid && o_out_data.sweep_done, o_out_data.accepted)
    `SAPSW_ASSERT_NEXT(a_set_cancels, i_clk, i_rst_n, w_in_acc && (i_in_data.kind == KIND_SET), !r_active)

endmodule

>>> tb/sv/servo_angle_pulse_sweeper_tb.sv
`timescale 1ns / 100ps

module servo_angle_pulse_sweeper_tb;

    import sapsw_pkg::*;

    localparam logic [1:0] KIND_UNUSED   = 2'd3;
    localparam int         RUN_LIMIT     = 1000000;
    localparam int         SETTLE_CYCLES = 64;
    localparam int         SEGMENTS      = 4;
    localparam int         SEGMENT_ITEMS = 140;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    t_in_item              req_data = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    t_out_item             rsp_data;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // mirror of the block's registers and sweep state
    int cfg_pulse_lo = PULSE_MIN_RST;
    int cfg_pulse_hi = PULSE_MAX_RST;
    int cfg_angle_lo = ANGLE_MIN_RST;
    int cfg_angle_hi = ANGLE_MAX_RST;
    bit cfg_enabled  = 1'b0;
    int cur_angle    = 0;
    bit ramp_on      = 1'b0;
    int ramp_pos     = 0;
    int ramp_end     = 0;
    int ramp_goal    = 0;
    int ramp_stride  = 0;
    int ramp_wait    = 0;
    int tick_cnt     = 0;

    t_out_item expected_pulses[$];
    int        mismatches      = 0;
    int        results_seen    = 0;
    int        acted_count     = 0;
    int        cycle_count     = 0;
    int        sender_idle_pct = 13;
    int        recv_idle_pct   = 63;

    servo_angle_pulse_sweeper u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_stall  (req_stall),
        .i_in_data   (req_data),
        .o_out_valid (rsp_valid),
        .i_out_stall (rsp_stall),
        .o_out_data  (rsp_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(negedge clk) begin
        rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    function automatic int clamp_deg(input int a);
        // upper bound first, so a reversed range never settles on a
        if (a > cfg_angle_hi) return cfg_angle_hi;
        if (a < cfg_angle_lo) return cfg_angle_lo;
        return a;
    endfunction

    function automatic int width_for_angle(input int a);
        int c;
        int span_in;
        c = clamp_deg(a);
        span_in = cfg_angle_hi - cfg_angle_lo;
        if (span_in == 0) return cfg_pulse_lo;
        return (c - cfg_angle_lo) * (cfg_pulse_hi - cfg_pulse_lo) / span_in + cfg_pulse_lo;
    endfunction

    function automatic void push_pulse(input int duty, input bit acc, input bit done);
        t_out_item p;
        p.duty_us    = duty[PULSE_W-1:0];
        p.accepted   = acc;
        p.sweep_done = done;
        expected_pulses.push_back(p);
    endfunction

    // returns 1 when the request did anything at all
    function automatic bit compute_pulse_response(input t_in_item req);
        int goal;
        int start_w;
        int final_w;
        int step;
        bit short_of;
        case (req.kind)
            KIND_SET: begin
                ramp_on = 1'b0;
                if (!cfg_enabled) begin
                    push_pulse(0, 1'b0, 1'b0);
                    return 1'b1;
                end
                cur_angle = clamp_deg(req.target_angle);
                push_pulse(width_for_angle(cur_angle), 1'b1, 1'b1);
                return 1'b1;
            end
            KIND_SWEEP: begin
                if (!cfg_enabled) begin
                    push_pulse(0, 1'b0, 1'b0);
                    return 1'b1;
                end
                goal    = clamp_deg(req.target_angle);
                start_w = width_for_angle(cur_angle);
                final_w = width_for_angle(goal);
                if (goal == cur_angle || start_w == final_w) begin
                    ramp_on   = 1'b0;
                    cur_angle = goal;
                    push_pulse(final_w, 1'b1, 1'b1);
                    return 1'b1;
                end
                step        = (req.step_us == 0) ? 1 : int'(req.step_us);
                ramp_stride = (final_w > start_w) ? step : -step;
                ramp_pos    = start_w + ramp_stride;
                ramp_end    = final_w;
                ramp_goal   = goal;
                ramp_wait   = req.step_delay_ms;
                tick_cnt    = 0;
                ramp_on     = 1'b1;
                push_pulse(start_w, 1'b1, 1'b0);
                return 1'b1;
            end
            KIND_TICK: begin
                if (!ramp_on || !cfg_enabled) return 1'b0;
                tick_cnt++;
                if (tick_cnt < ramp_wait) return 1'b1;
                tick_cnt = 0;
                short_of = (ramp_stride > 0) ? (ramp_pos < ramp_end) : (ramp_pos > ramp_end);
                if (short_of) begin
                    push_pulse(ramp_pos, 1'b1, 1'b0);
                    ramp_pos += ramp_stride;
                    return 1'b1;
                end
                ramp_on   = 1'b0;
                cur_angle = ramp_goal;
                push_pulse(ramp_end, 1'b1, 1'b1);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_in_item make_request(input logic [1:0] kind, input int angle,
                                              input int step, input int delay);
        t_in_item r;
        r.kind          = kind;
        r.target_angle  = angle[ANGLE_W-1:0];
        r.step_us       = step[STEP_W-1:0];
        r.step_delay_ms = delay[DELAY_W-1:0];
        return r;
    endfunction

    function automatic int pick_bound(input int lo, input int hi, input int typ_lo,
                                      input int typ_hi);
        case ($urandom_range(0, 4))
            0: return lo;
            1: return hi;
            2: return $urandom_range(lo, hi);
            default: return $urandom_range(typ_lo, typ_hi);
        endcase
    endfunction

    task automatic note_mismatch(input string what, input t_out_item want, input t_out_item got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at result %0d (%s): expected duty=%0d acc=%0b done=%0b, got duty=%0d acc=%0b done=%0b",
                     results_seen, what, want.duty_us, want.accepted, want.sweep_done,
                     got.duty_us, got.accepted, got.sweep_done);
    endtask

    always @(posedge clk) begin : check_results
        t_out_item want;
        if (rst_n && rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_pulses.size() == 0) begin
                note_mismatch("none expected", '0, rsp_data);
            end else begin
                want = expected_pulses.pop_front();
                if (rsp_data.duty_us !== want.duty_us || rsp_data.accepted !== want.accepted
                        || rsp_data.sweep_done !== want.sweep_done)
                    note_mismatch("field differs", want, rsp_data);
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_request(input t_in_item req);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= req;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        if (compute_pulse_response(req)) acted_count++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (expected_pulses.size() != 0) @(negedge clk);
        // ticks that leave no result may still be in flight
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_PULSE_MIN: cfg_pulse_lo = value & 16'h7FFF;
            CFG_PULSE_MAX: cfg_pulse_hi = value & 16'h7FFF;
            CFG_ANGLE_MIN: cfg_angle_lo = value & 8'hFF;
            CFG_ANGLE_MAX: cfg_angle_hi = value & 8'hFF;
            CFG_ENABLE:    cfg_enabled  = value[0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic apply_settings(input int pulse_lo, input int pulse_hi, input int angle_lo,
                                  input int angle_hi, input int enabled);
        write_register(CFG_PULSE_MIN, pulse_lo);
        write_register(CFG_PULSE_MAX, pulse_hi);
        write_register(CFG_ANGLE_MIN, angle_lo);
        write_register(CFG_ANGLE_MAX, angle_hi);
        write_register(CFG_ENABLE, enabled);
    endtask

    task automatic test_disabled_output();
        send_request(make_request(KIND_SET, 90, 100, 1));
        send_request(make_request(KIND_SWEEP, 45, 100, 1));
        send_request(make_request(KIND_TICK, 0, 0, 0));
        send_request(make_request(KIND_UNUSED, 255, 32767, 65535));
        wait_drained();
    endtask

    task automatic test_set_mapping();
        apply_settings(PULSE_MIN_RST, PULSE_MAX_RST, ANGLE_MIN_RST, ANGLE_MAX_RST, 1);
        send_request(make_request(KIND_SET, 0, 0, 0));
        send_request(make_request(KIND_SET, 255, 0, 0));
        send_request(make_request(KIND_SET, 45, 0, 0));
    endtask

    task automatic test_sweep_ramp();
        send_request(make_request(KIND_SWEEP, 180, 400, 0));
        repeat (3) send_request(make_request(KIND_TICK, 0, 0, 0));
    endtask

    task automatic test_sweep_cancel();
        // step 0 acts as 1, longest delay, then a set cuts the sweep off
        send_request(make_request(KIND_SWEEP, 0, 0, 65535));
        send_request(make_request(KIND_TICK, 0, 0, 0));
        send_request(make_request(KIND_SET, 90, 0, 0));
        send_request(make_request(KIND_TICK, 0, 0, 0));
    endtask

    task automatic test_sweep_same_goal();
        send_request(make_request(KIND_SWEEP, 90, 20000, 1));
        wait_drained();
    endtask

    task automatic test_angle_range_corners();
        apply_settings(PULSE_MIN_RST, PULSE_MAX_RST, 50, 50, 1);
        send_request(make_request(KIND_SET, 200, 0, 0));
        wait_drained();
        // reversed angle range
        apply_settings(PULSE_MIN_RST, PULSE_MAX_RST, 200, 10, 1);
        send_request(make_request(KIND_SET, 255, 0, 0));
        send_request(make_request(KIND_SET, 5, 0, 0));
        wait_drained();
    endtask

    task automatic test_reversed_pulse_range();
        apply_settings(20000, 0, 0, 255, 1);
        send_request(make_request(KIND_SET, 0, 0, 0));
        send_request(make_request(KIND_SWEEP, 255, 16384, 1));
        repeat (2) send_request(make_request(KIND_TICK, 0, 0, 0));
        wait_drained();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        int seg;
        int base;
        int pick;
        int span;
        int step;
        int delay;
        int n;
        int gap;
        int i;
        sender_idle_pct = send_pct;
        recv_idle_pct   = recv_pct;
        for (seg = 0; seg < SEGMENTS; seg++) begin
            wait_drained();
            if (seg == 0)
                apply_settings(0, 20000, 0, 255, 1);
            else if (seg == 1)
                apply_settings(20000, 0, 255, 0, 1);
            else
                apply_settings(pick_bound(0, 20000, 500, 2500), pick_bound(0, 20000, 500, 2500),
                               pick_bound(0, 255, 0, 60), pick_bound(0, 255, 120, 255),
                               ($urandom_range(0, 99) < 85));
            base = acted_count;
            while (acted_count - base < SEGMENT_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    // a sweep followed by ticks, usually enough to finish it, with some noise
                    span = cfg_pulse_hi - cfg_pulse_lo;
                    if (span < 0) span = -span;
                    pick = $urandom_range(0, 9);
                    if (pick == 0) step = 0;
                    else if (pick == 1) step = $urandom_range(0, 20000);
                    else step = $urandom_range(1, span / 3 + 1);
                    pick = $urandom_range(0, 9);
                    if (pick < 6) delay = $urandom_range(0, 2);
                    else if (pick < 9) delay = $urandom_range(3, 6);
                    else delay = $urandom_range(0, 65535);
                    send_request(make_request(KIND_SWEEP, $urandom_range(0, 255), step, delay));
                    n = 0;
                    if (ramp_on) begin
                        gap = ramp_end - ramp_pos;
                        if (gap < 0) gap = -gap;
                        n = (gap / ((ramp_stride < 0) ? -ramp_stride : ramp_stride) + 2)
                            * ((ramp_wait == 0) ? 1 : ramp_wait);
                        if (ramp_wait > 6) n = $urandom_range(1, 3);
                        if (n > 80) n = 80;
                    end
                    for (i = 0; i < n; i++) begin
                        pick = $urandom_range(0, 99);
                        if (pick < 5)
                            send_request(make_request(KIND_SET, $urandom_range(0, 255), 0, 0));
                        else if (pick < 8)
                            send_request(make_request(KIND_UNUSED, $urandom_range(0, 255),
                                                      $urandom_range(0, 20000),
                                                      $urandom_range(0, 65535)));
                        else
                            send_request(make_request(KIND_TICK, 0, 0, 0));
                    end
                end else if (pick < 75) begin
                    send_request(make_request(KIND_SET, $urandom_range(0, 255),
                                              $urandom_range(0, 20000), $urandom_range(0, 65535)));
                end else if (pick < 85) begin
                    send_request(make_request(KIND_TICK, $urandom_range(0, 255),
                                              $urandom_range(0, 20000), $urandom_range(0, 65535)));
                end else begin
                    send_request(make_request(2'($urandom_range(0, 3)), $urandom_range(0, 255),
                                              $urandom_range(0, 20000), $urandom_range(0, 65535)));
                end
            end
        end
    endtask

    initial begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_disabled_output();
        test_set_mapping();
        test_sweep_ramp();
        test_sweep_cancel();
        test_sweep_same_goal();
        test_angle_range_corners();
        test_reversed_pulse_range();
        test_random_traffic(13, 63);
        test_random_traffic(63, 13);
        test_random_traffic(0, 0);
        wait_drained();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
